### src/pbc_pkg.sv
// Shared types and constants of the packed pixel to BGRA converter.
`default_nettype none

package pbc_pkg;

    typedef enum logic [1:0] {
        FMT_RGB32  = 2'd0,
        FMT_RGB24  = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_YUYV   = 2'd3
    } t_format;

    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_DEST_WIDTH    = 2'd2;
    localparam logic [1:0] REG_DEST_HEIGHT   = 2'd3;

    localparam int CNT_W = 13;
    localparam int POS_W = 12;
    localparam logic [CNT_W-1:0] ROW_TOP = 13'd8191;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int SUM_W = 20;
    localparam logic signed [SUM_W-1:0] K_Y     = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_RV    = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_GU    = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_GV    = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_BU    = 20'sd516;
    localparam logic signed [SUM_W-1:0] Y_OFS   = 20'sd16;
    localparam logic signed [SUM_W-1:0] UV_OFS  = 20'sd128;
    localparam logic signed [SUM_W-1:0] ROUND   = 20'sd128;
    localparam logic [7:0]              CH_MAX  = 8'd255;

    localparam logic [15:0] MASK_B565 = 16'h001F;
    localparam logic [15:0] MASK_G565 = 16'h07E0;
    localparam logic [15:0] MASK_R565 = 16'hF800;

    typedef struct packed {
        t_format          format;
        logic [CNT_W-1:0] source_width;
        logic [CNT_W-1:0] dest_width;
        logic [CNT_W-1:0] dest_height;
    } t_cfg;

    typedef struct packed {
        logic [31:0]      word;
        t_format          format;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             emit1;
    } t_entry;

endpackage

`default_nettype wire

### src/pbc_front.sv
// Front end: accepts source words, keeps the column and row counters, classifies pixels.
`default_nettype none

module pbc_front #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_LINES       = 4096
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pbc_pkg::t_cfg    i_cfg,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [31:0]      i_word,
    input  wire              i_frame_start,
    input  wire              i_full,
    output logic             o_push,
    output pbc_pkg::t_entry  o_entry
);
    import pbc_pkg::*;

    localparam logic [CNT_W:0] DW_CAP = (CNT_W+1)'(MAX_LINE_PIXELS);
    localparam logic [CNT_W:0] DH_CAP = (CNT_W+1)'(MAX_LINES);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] col_cur, row_cur;
    logic [CNT_W:0]   dw, dh, col_p1, col_next;
    logic             is_yuyv, row_ok, emit0, emit1, accept, wrap;

    always_comb begin
        dw = ({1'b0, i_cfg.dest_width} < DW_CAP) ? {1'b0, i_cfg.dest_width} : DW_CAP;
        dh = ({1'b0, i_cfg.dest_height} < DH_CAP) ? {1'b0, i_cfg.dest_height} : DH_CAP;
        is_yuyv  = (i_cfg.format == FMT_YUYV);
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        row_ok   = ({1'b0, row_cur} < dh);
        col_p1   = {1'b0, col_cur} + (CNT_W+1)'(1);
        emit0    = row_ok && ({1'b0, col_cur} < dw);
        emit1    = is_yuyv && row_ok && (col_p1 < dw);
        col_next = {1'b0, col_cur} + (is_yuyv ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
        wrap     = (col_next >= {1'b0, i_cfg.source_width});
        o_ready  = !i_full;
        accept   = i_valid && !i_full;
        o_push   = accept && (emit0 || emit1);

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (wrap) begin
                n_col = '0;
                n_row = (row_cur < ROW_TOP) ? row_cur + CNT_W'(1) : row_cur;
            end else begin
                n_col = col_next[CNT_W-1:0];
                n_row = row_cur;
            end
        end

        o_entry.word   = i_word;
        o_entry.format = i_cfg.format;
        o_entry.col    = col_cur[POS_W-1:0];
        o_entry.row    = row_cur[POS_W-1:0];
        o_entry.emit1  = emit1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

### src/pbc_queue.sv
// Short queue of classified words between the front and back ends.
`default_nettype none

module pbc_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pbc_pkg::t_entry  i_entry,
    input  wire              i_pop,
    output pbc_pkg::t_entry  o_head,
    output logic             o_empty,
    output logic             o_full
);
    import pbc_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    always_comb begin
        o_empty  = (r_count == '0);
        o_full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
        o_head   = r_mem[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### src/pbc_back.sv
// Back end: converts queued words to BGRA pixels and holds the output register.
`default_nettype none

module pbc_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  pbc_pkg::t_entry             i_head,
    input  wire                         i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [7:0]                  o_blue,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_alpha,
    output logic [pbc_pkg::POS_W-1:0]   o_column,
    output logic [pbc_pkg::POS_W-1:0]   o_row,
    output logic                        o_last
);
    import pbc_pkg::*;

    function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = s + ROUND;
        if (v < 0) begin
            return 8'd0;
        end else if (v[SUM_W-1:16] != '0) begin
            return CH_MAX;
        end else begin
            return v[15:8];
        end
    endfunction

    logic                    r_phase, n_phase;
    logic                    r_out_valid, n_out_valid;
    logic [7:0]              r_blue, r_green, r_red, r_alpha;
    logic [POS_W-1:0]        r_column, r_row;
    logic                    r_last;
    logic                    can_load, advance, last;
    logic [7:0]              b0, b1, b2, b3, y, pb, pg, pr, pa;
    logic [15:0]             p565;
    logic signed [SUM_W-1:0] c, d, e, yc;

    always_comb begin
        b0   = i_head.word[7:0];
        b1   = i_head.word[15:8];
        b2   = i_head.word[23:16];
        b3   = i_head.word[31:24];
        p565 = i_head.word[15:0];
        y    = r_phase ? b2 : b0;
        c    = $signed({{(SUM_W-8){1'b0}}, y}) - Y_OFS;
        d    = $signed({{(SUM_W-8){1'b0}}, b1}) - UV_OFS;
        e    = $signed({{(SUM_W-8){1'b0}}, b3}) - UV_OFS;
        yc   = K_Y * c;

        pa = CH_MAX;
        case (i_head.format)
            FMT_RGB32: begin
                pb = b0;
                pg = b1;
                pr = b2;
                pa = b3;
            end
            FMT_RGB24: begin
                pb = b0;
                pg = b1;
                pr = b2;
            end
            FMT_RGB565: begin
                pb = 8'((p565 & MASK_B565) << 3);
                pg = 8'((p565 & MASK_G565) >> 3);
                pr = 8'((p565 & MASK_R565) >> 8);
            end
            FMT_YUYV: begin
                pr = clamp_channel(yc + K_RV * e);
                pg = clamp_channel(yc - K_GU * d - K_GV * e);
                pb = clamp_channel(yc + K_BU * d);
            end
            default: begin
                pb = b0;
                pg = b1;
                pr = b2;
            end
        endcase

        last        = r_phase || !i_head.emit1;
        can_load    = !r_out_valid || i_ready;
        advance     = !i_empty && can_load;
        o_pop       = advance && last;
        n_phase     = advance ? !last : r_phase;
        n_out_valid = advance ? 1'b1 : (r_out_valid && !i_ready);

        o_valid  = r_out_valid;
        o_blue   = r_blue;
        o_green  = r_green;
        o_red    = r_red;
        o_alpha  = r_alpha;
        o_column = r_column;
        o_row    = r_row;
        o_last   = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_blue   <= pb;
            r_green  <= pg;
            r_red    <= pr;
            r_alpha  <= pa;
            r_column <= i_head.col + POS_W'(r_phase);
            r_row    <= i_head.row;
            r_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### src/packed_pixel_to_bgra_converter_unit.sv
// Top level of the packed pixel to BGRA converter: configuration registers and block wiring.
`default_nettype none

// The converter takes one packed source word per transfer and delivers BGRA pixels with their
// destination column and row. A source word is accepted in every cycle while the four-entry
// queue between the front and back ends has room. The single output register delivers one
// pixel per cycle unless m_axis_tready stalls it, so RGB32, RGB24 and RGB565 run at one word
// per cycle and YUYV, two pixels per word, delivers them in turn. A word whose pixels all
// fall outside the destination delivers nothing; the rest pass the queue and output register.
// The user writes configuration only while the block is idle; the block does not enforce it.

module packed_pixel_to_bgra_converter_unit #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_LINES       = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [12:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] source_word
    input  wire         s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // blue, green, red, alpha, pixel_column, pixel_row
    output logic        m_axis_tlast
);
    import pbc_pkg::*;

    t_cfg             r_cfg;
    t_entry           push_entry, head;
    logic             push, pop, empty, full;
    logic [7:0]       blue, green, red, alpha;
    logic [POS_W-1:0] column, row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format       <= FMT_RGB32;
            r_cfg.source_width <= 13'd320;
            r_cfg.dest_width   <= 13'd320;
            r_cfg.dest_height  <= 13'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_FORMAT: r_cfg.format       <= t_format'(i_cfg_data[1:0]);
                REG_SOURCE_WIDTH:  r_cfg.source_width <= i_cfg_data;
                REG_DEST_WIDTH:    r_cfg.dest_width   <= i_cfg_data;
                REG_DEST_HEIGHT:   r_cfg.dest_height  <= i_cfg_data;
                default:           r_cfg              <= r_cfg;
            endcase
        end
    end

    pbc_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_LINES       (MAX_LINES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_word        (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    pbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    pbc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_blue   (blue),
        .o_green  (green),
        .o_red    (red),
        .o_alpha  (alpha),
        .o_column (column),
        .o_row    (row),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {row, column, alpha, red, green, blue};

endmodule

`default_nettype wire

### bench/packed_pixel_to_bgra_converter_unit_test.sv
// Self-checking testbench for the packed pixel to BGRA converter, with its own pixel predictor.
module packed_pixel_to_bgra_converter_unit_test;
    import pbc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD = 60;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } t_pixel;

    typedef struct packed {
        t_format     fmt;
        logic [12:0] sw;
        logic [12:0] dw;
        logic [12:0] dh;
        logic [31:0] word;
        logic        fs;
        logic        typed;
        logic [31:0] bgra;
    } t_word_row;

    localparam int NUM_ROWS = 25;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] source_word
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // blue, green, red, alpha, pixel_column, pixel_row
    logic        m_axis_tlast;

    t_pixel      expected_pixels[$];
    int          mismatches = 0;
    bit          calm = 0;
    int unsigned hold_asks = 0;
    int          idle_cycles = 0;

    t_format     cfg_format = FMT_RGB32;
    int          cfg_source_width = 320;
    int          cfg_dest_width = 320;
    int          cfg_dest_height = 240;
    int          column_count = 0;
    int          row_count = 0;

    t_word_row directed_rows [NUM_ROWS] = '{
        '{FMT_RGB32,  13'd320,  13'd320,  13'd240,  32'h00000000, 1'b1, 1'b1, 32'h00000000},
        '{FMT_RGB32,  13'd320,  13'd320,  13'd240,  32'hFFFFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
        '{FMT_RGB32,  13'd320,  13'd320,  13'd240,  32'h80402010, 1'b0, 1'b1, 32'h80402010},
        '{FMT_RGB24,  13'd320,  13'd320,  13'd240,  32'hAA123456, 1'b0, 1'b1, 32'hFF123456},
        '{FMT_RGB24,  13'd320,  13'd320,  13'd240,  32'h00FFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
        '{FMT_RGB565, 13'd320,  13'd320,  13'd240,  32'hFFFF0000, 1'b0, 1'b1, 32'hFF000000},
        '{FMT_RGB565, 13'd320,  13'd320,  13'd240,  32'h0000FFFF, 1'b0, 1'b1, 32'hFFF8FCF8},
        '{FMT_RGB565, 13'd320,  13'd320,  13'd240,  32'h0000F800, 1'b0, 1'b1, 32'hFFF80000},
        '{FMT_RGB565, 13'd320,  13'd320,  13'd240,  32'h000007E0, 1'b0, 1'b1, 32'hFF00FC00},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'h80108010, 1'b0, 1'b1, 32'hFF000000},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'h80EB80EB, 1'b0, 1'b1, 32'hFFFFFFFF},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'hFFFFFFFF, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'h00000000, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'hFF00FF00, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd320,  13'd320,  13'd240,  32'h00FF00FF, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd3,    13'd320,  13'd240,  32'h12345678, 1'b1, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd3,    13'd320,  13'd240,  32'h9ABCDEF0, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd3,    13'd320,  13'd240,  32'h55AA55AA, 1'b0, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd3,    13'd3,    13'd240,  32'h80808080, 1'b1, 1'b0, 32'h0},
        '{FMT_YUYV,   13'd3,    13'd3,    13'd240,  32'h4080C0FF, 1'b0, 1'b0, 32'h0},
        '{FMT_RGB32,  13'd0,    13'd320,  13'd240,  32'h11223344, 1'b1, 1'b0, 32'h0},
        '{FMT_RGB32,  13'd0,    13'd320,  13'd240,  32'h55667788, 1'b0, 1'b0, 32'h0},
        '{FMT_RGB24,  13'd320,  13'd0,    13'd240,  32'h01020304, 1'b0, 1'b0, 32'h0},
        '{FMT_RGB565, 13'd320,  13'd320,  13'd0,    32'h0000FFFF, 1'b0, 1'b0, 32'h0},
        '{FMT_RGB32,  13'd8191, 13'd8191, 13'd8191, 32'hDEADBEEF, 1'b1, 1'b0, 32'h0}
    };

    packed_pixel_to_bgra_converter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] clip_channel(input int sum);
        int v;
        v = sum + 128;
        if (v < 0) begin
            return 8'd0;
        end
        v = v / 256;
        if (v > 255) begin
            return 8'd255;
        end
        return 8'(v);
    endfunction

    function automatic t_pixel yuv_pixel(input logic [7:0] luma, input int d, input int e,
                                         input int col, input int row);
        int     c;
        t_pixel px;
        c = luma;
        c = c - 16;
        px.red    = clip_channel(298 * c + 409 * e);
        px.green  = clip_channel(298 * c - 100 * d - 208 * e);
        px.blue   = clip_channel(298 * c + 516 * d);
        px.alpha  = 8'hFF;
        px.column = 12'(col);
        px.row    = 12'(row);
        px.last   = 1'b0;
        return px;
    endfunction

    // Works out the pixels that one accepted source word yields and advances the counters.
    task automatic convert_word(input logic [31:0] w, input bit fs, output int produced);
        int     col;
        int     row;
        int     dw;
        int     dh;
        int     step;
        int     d;
        int     e;
        bit     row_ok;
        t_pixel px;
        if (fs) begin
            column_count = 0;
            row_count = 0;
        end
        col = column_count;
        row = row_count;
        dw = (cfg_dest_width < 4096) ? cfg_dest_width : 4096;
        dh = (cfg_dest_height < 4096) ? cfg_dest_height : 4096;
        row_ok = row < dh;
        step = 1;
        produced = 0;
        if (cfg_format == FMT_YUYV) begin
            step = 2;
            d = w[15:8];
            d = d - 128;
            e = w[31:24];
            e = e - 128;
            if (row_ok && col < dw) begin
                expected_pixels.push_back(yuv_pixel(w[7:0], d, e, col, row));
                produced++;
            end
            if (row_ok && col + 1 < dw) begin
                expected_pixels.push_back(yuv_pixel(w[23:16], d, e, col + 1, row));
                produced++;
            end
        end else if (row_ok && col < dw) begin
            px.alpha = 8'hFF;
            case (cfg_format)
                FMT_RGB32: begin
                    {px.alpha, px.red, px.green, px.blue} = w;
                end
                FMT_RGB24: begin
                    {px.red, px.green, px.blue} = w[23:0];
                end
                default: begin
                    px.blue  = {w[4:0], 3'b000};
                    px.green = {w[10:5], 2'b00};
                    px.red   = {w[15:11], 3'b000};
                end
            endcase
            px.column = 12'(col);
            px.row    = 12'(row);
            px.last   = 1'b0;
            expected_pixels.push_back(px);
            produced++;
        end
        if (produced > 0) begin
            px = expected_pixels[expected_pixels.size() - 1];
            px.last = 1'b1;
            expected_pixels[expected_pixels.size() - 1] = px;
        end
        col = col + step;
        if (col >= cfg_source_width) begin
            col = 0;
            if (row < int'(ROW_TOP)) begin
                row++;
            end
        end
        column_count = col & 32'h1FFF;
        row_count = row & 32'h1FFF;
    endtask

    task automatic check_pixel(input logic [55:0] data, input logic last);
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            report_mismatch("pixel with none expected", 64'(data), 64'd0);
        end else begin
            want = expected_pixels.pop_front();
            if (data[7:0] !== want.blue) begin
                report_mismatch("blue", 64'(data[7:0]), 64'(want.blue));
            end
            if (data[15:8] !== want.green) begin
                report_mismatch("green", 64'(data[15:8]), 64'(want.green));
            end
            if (data[23:16] !== want.red) begin
                report_mismatch("red", 64'(data[23:16]), 64'(want.red));
            end
            if (data[31:24] !== want.alpha) begin
                report_mismatch("alpha", 64'(data[31:24]), 64'(want.alpha));
            end
            if (data[43:32] !== want.column) begin
                report_mismatch("pixel_column", 64'(data[43:32]), 64'(want.column));
            end
            if (data[55:44] !== want.row) begin
                report_mismatch("pixel_row", 64'(data[55:44]), 64'(want.row));
            end
            if (last !== want.last) begin
                report_mismatch("last", 64'(last), 64'(want.last));
            end
        end
    endtask

    task automatic send_word(input logic [31:0] w, input bit fs, output int produced);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        convert_word(w, fs, produced);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_format fmt, input int sw, input int dw, input int dh);
        write_reg(REG_SOURCE_FORMAT, {11'd0, fmt});
        write_reg(REG_SOURCE_WIDTH, 13'(sw));
        write_reg(REG_DEST_WIDTH, 13'(dw));
        write_reg(REG_DEST_HEIGHT, 13'(dh));
        i_cfg_we <= 1'b0;
        cfg_format = fmt;
        cfg_source_width = sw;
        cfg_dest_width = dw;
        cfg_dest_height = dh;
    endtask

    function automatic int pick_size(input int top_small);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 8191;
            2: return 4096;
            3: return $urandom_range(1, 8191);
            default: return $urandom_range(1, top_small);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: checks each transfer and decides readiness for the next cycle.
    initial begin
        int          hold_left;
        int unsigned holds_served;
        hold_left = 0;
        holds_served = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_pixel(m_axis_tdata, m_axis_tlast);
            end
            if (holds_served != hold_asks) begin
                holds_served = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                hold_left = $urandom_range(1, 6) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int        produced;
        int        num_items;
        int        first;
        t_word_row row;
        t_pixel    px;
        t_format   fmt;
        int        sw;
        int        dw;
        int        dh;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_SOURCE_FORMAT;
        i_cfg_data    <= 13'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tuser  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = directed_rows[i];
            if (row.fmt != cfg_format || int'(row.sw) != cfg_source_width ||
                int'(row.dw) != cfg_dest_width || int'(row.dh) != cfg_dest_height) begin
                wait_idle();
                set_config(row.fmt, row.sw, row.dw, row.dh);
            end
            send_word(row.word, row.fs, produced);
            if (row.typed) begin
                first = expected_pixels.size() - produced;
                for (int k = first; k < expected_pixels.size(); k++) begin
                    px = expected_pixels[k];
                    {px.alpha, px.red, px.green, px.blue} = row.bgra;
                    expected_pixels[k] = px;
                end
            end
        end

        // One word per line, running on past the destination height.
        wait_idle();
        set_config(FMT_RGB24, 1, 4096, 20);
        send_word($urandom, 1'b1, produced);
        for (int i = 0; i < 40; i++) begin
            send_word($urandom, 1'b0, produced);
        end

        for (int phase = 0; phase < 12; phase++) begin
            fmt = t_format'($urandom_range(0, 3));
            if (phase == 0) begin
                sw = 1;
                dw = 1;
                dh = 1;
            end else if (phase == 1) begin
                sw = 8191;
                dw = 8191;
                dh = 8191;
            end else begin
                sw = pick_size(12);
                dw = pick_size(16);
                dh = pick_size(20);
            end
            wait_idle();
            set_config(fmt, sw, dw, dh);
            calm = (phase >= 10);
            num_items = 95 + $urandom_range(0, 10);
            for (int k = 0; k < num_items; k++) begin
                if (phase == 1 && k == 20) begin
                    hold_asks++;
                end
                send_word($urandom, (k == 0) || ($urandom_range(0, 15) == 0), produced);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
